### src/alr_pkg.sv
// ----------------------------------------------------------------------------
// alr_pkg
// Types, codes and G.711 helper functions for the A-law line to PCM resampler.
// ----------------------------------------------------------------------------
package alr_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_BIT_REVERSE   = 2'd0;
    localparam logic [1:0] REG_OUT_FORMAT    = 2'd1;
    localparam logic [1:0] REG_RATE_RATIO    = 2'd2;
    localparam logic [1:0] REG_RECORD_ENABLE = 2'd3;

    // output format codes
    localparam logic [2:0] FMT_U8    = 3'd0;
    localparam logic [2:0] FMT_S8    = 3'd1;
    localparam logic [2:0] FMT_MULAW = 3'd2;
    localparam logic [2:0] FMT_ALAW  = 3'd3;
    localparam logic [2:0] FMT_S16LE = 3'd4;
    localparam logic [2:0] FMT_S16BE = 3'd5;
    localparam logic [2:0] FMT_U16LE = 3'd6;
    localparam logic [2:0] FMT_U16BE = 3'd7;

    localparam logic [3:0] MAX_COPIES  = 4'd15;
    localparam int         QUEUE_DEPTH = 4;
    localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] DEF_RATE_RATIO = 16'd4096;

    typedef struct packed {
        logic        bit_reverse;
        logic [2:0]  out_format;
        logic [15:0] rate_ratio;
        logic        record_enable;
    } alr_cfg_t;

    // one decoded sample with its repeat count
    typedef struct packed {
        logic [7:0]         pcm0;
        logic [7:0]         pcm1;
        logic               wide;
        logic [3:0]         copies;
        logic signed [15:0] rec;
        logic [7:0]         peak;
    } alr_item_t;

    function automatic logic [7:0] reverse_byte(input logic [7:0] c);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7-k] = c[k];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] alaw_expand(input logic [7:0] code);
        logic [7:0]  a;
        logic [2:0]  seg;
        logic [15:0] t;
        a   = code ^ 8'h55;
        seg = a[6:4];
        if (seg == 3'd0) begin
            t = {8'd0, a[3:0], 4'h8};
        end
        else begin
            t = (16'h0108 + {8'd0, a[3:0], 4'h0}) << (seg - 3'd1);
        end
        return a[7] ? $signed(t) : -$signed(t);
    endfunction

    function automatic logic [7:0] mulaw_compress(input logic signed [15:0] s);
        logic signed [15:0] q;
        logic [15:0]        magw;
        logic [13:0]        mag;
        logic [7:0]         mask;
        logic [3:0]         seg;
        logic [13:0]        sh;
        logic [7:0]         code;
        q    = s >>> 2;
        magw = s[15] ? 16'(-q) : 16'(q);
        mask = s[15] ? 8'h7F : 8'hFF;
        if (magw > 16'd8159) begin
            magw = 16'd8159;
        end
        mag = magw[13:0] + 14'h21;
        if (mag[13])      seg = 4'd8;
        else if (mag[12]) seg = 4'd7;
        else if (mag[11]) seg = 4'd6;
        else if (mag[10]) seg = 4'd5;
        else if (mag[9])  seg = 4'd4;
        else if (mag[8])  seg = 4'd3;
        else if (mag[7])  seg = 4'd2;
        else if (mag[6])  seg = 4'd1;
        else              seg = 4'd0;
        sh = mag >> (seg + 4'd1);
        if (seg[3]) begin
            code = 8'h7F ^ mask;
        end
        else begin
            code = {1'b0, seg[2:0], sh[3:0]} ^ mask;
        end
        return code;
    endfunction

endpackage

### src/alr_front.sv
// ----------------------------------------------------------------------------
// alr_front
// Decodes a line byte, formats the PCM bytes, runs the phase accumulator and
// the block peak, and queues one item per sample that has copies due.
// ----------------------------------------------------------------------------
module alr_front
    import alr_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 12
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  alr_cfg_t  cfg,
    input  logic      push,
    output logic      full,
    input  logic [7:0] line_byte,
    input  logic      end_of_block,
    input  logic      q_full,
    output logic      q_push,
    output alr_item_t q_data
);

    localparam int ACC_W = 17;

    logic [RATIO_FRAC_BITS-1:0] phase_reg, phase_next;
    logic [7:0]                 peak_reg, peak_next;

    logic               accept;
    logic [7:0]         byte_r;
    logic signed [15:0] s;
    logic [15:0]        mag;
    logic [7:0]         level;
    logic [7:0]         peak_max;
    logic [7:0]         s8;
    logic [7:0]         hi;
    logic [7:0]         lo;
    logic [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]   copies_wide;
    logic [3:0]         copies;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        byte_r      = cfg.bit_reverse ? reverse_byte(line_byte) : line_byte;
        s           = alaw_expand(byte_r);
        mag         = s[15] ? 16'(-s) : 16'(s);
        level       = mag[15:8];
        peak_max    = (level > peak_reg) ? level : peak_reg;
        s8          = s[15] ? 8'(-level) : level;
        lo          = s[7:0];
        hi          = s[15:8] ^ ((cfg.out_format == FMT_U16LE ||
                                  cfg.out_format == FMT_U16BE) ? 8'h80 : 8'h00);

        acc         = ACC_W'(phase_reg) + ACC_W'(cfg.rate_ratio);
        copies_wide = acc >> RATIO_FRAC_BITS;
        copies      = (copies_wide > ACC_W'(MAX_COPIES)) ? MAX_COPIES : copies_wide[3:0];

        q_data.pcm1   = 8'h00;
        q_data.wide   = 1'b0;
        case (cfg.out_format)
            FMT_U8:    q_data.pcm0 = s8 ^ 8'h80;
            FMT_S8:    q_data.pcm0 = s8;
            FMT_MULAW: q_data.pcm0 = mulaw_compress(s);
            FMT_ALAW:  q_data.pcm0 = byte_r;
            FMT_S16LE, FMT_U16LE:
            begin
                q_data.pcm0 = lo;
                q_data.pcm1 = hi;
                q_data.wide = 1'b1;
            end
            default:
            begin
                q_data.pcm0 = hi;
                q_data.pcm1 = lo;
                q_data.wide = 1'b1;
            end
        endcase
        q_data.copies = copies;
        q_data.rec    = cfg.record_enable ? s : 16'sd0;
        q_data.peak   = peak_max;

        q_push     = accept && (copies != 4'd0);
        phase_next = end_of_block ? '0 : acc[RATIO_FRAC_BITS-1:0];
        peak_next  = end_of_block ? 8'd0 : peak_max;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= '0;
            peak_reg  <= 8'd0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
            peak_reg  <= peak_next;
        end
    end

endmodule

### src/alr_queue.sv
// ----------------------------------------------------------------------------
// alr_queue
// Small FIFO of decoded items between the front and the back end.
// ----------------------------------------------------------------------------
module alr_queue
    import alr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  alr_item_t wr_data,
    output logic      q_full,
    input  logic      rd_en,
    output alr_item_t rd_data,
    output logic      q_empty
);

    localparam logic [QPTR_W:0] DEPTH = (QPTR_W+1)'(QUEUE_DEPTH);

    alr_item_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_wr, do_rd;

    assign q_full  = (count_reg == DEPTH);
    assign q_empty = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH)
        else $error("queue count above depth");
    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on write");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

### src/alr_back.sv
// ----------------------------------------------------------------------------
// alr_back
// Holds the current item and plays out its copies one byte per word.
// ----------------------------------------------------------------------------
module alr_back
    import alr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  alr_item_t   q_data,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  pcm_byte,
    output logic        run_last,
    output logic signed [15:0] record_sample,
    output logic [7:0]  block_peak
);

    alr_item_t  cur_reg, cur_next;
    logic [3:0] left_reg, left_next;
    logic       sel_reg, sel_next;
    logic       valid_reg, valid_next;
    logic       advance, finishing;

    assign empty         = !valid_reg;
    assign pcm_byte      = sel_reg ? cur_reg.pcm1 : cur_reg.pcm0;
    assign run_last      = (left_reg == 4'd1) && (!cur_reg.wide || sel_reg);
    assign record_sample = cur_reg.rec;
    assign block_peak    = cur_reg.peak;

    assign advance   = valid_reg && pop;
    assign finishing = advance && run_last;
    assign q_pop     = (!valid_reg || finishing) && !q_empty;

    always_comb
    begin
        cur_next   = cur_reg;
        left_next  = left_reg;
        sel_next   = sel_reg;
        valid_next = valid_reg;
        if (q_pop) begin
            cur_next   = q_data;
            left_next  = q_data.copies;
            sel_next   = 1'b0;
            valid_next = 1'b1;
        end
        else if (finishing) begin
            valid_next = 1'b0;
        end
        else if (advance) begin
            if (!cur_reg.wide || sel_reg) begin
                sel_next  = 1'b0;
                left_next = left_reg - 1'b1;
            end
            else begin
                sel_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            left_reg  <= 4'd0;
            sel_reg   <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
            sel_reg   <= sel_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (left_reg != 4'd0))
        else $error("active item with no copies left");
    a_sel_wide: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && sel_reg) |-> cur_reg.wide)
        else $error("second byte selected on narrow format");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (finishing && q_empty) |=> empty)
        else $error("output not empty after last word with nothing queued");
`endif

endmodule

### src/alaw_line_to_pcm_resampler_top.sv
// ----------------------------------------------------------------------------
// alaw_line_to_pcm_resampler_top
// A-law line bytes in, rate-converted PCM bytes in a selectable format out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive line_byte/end_of_block and raise push; the word
//   is taken at an edge where full is low. One word per cycle is taken while
//   the four-entry item queue has room.
//   Output queue side: while empty is low the oldest result sits on pcm_byte,
//   run_last, record_sample and block_peak; pop takes it. One result per
//   cycle while pop is high and results are queued; a sample gives 0 to 15
//   copies of one or two bytes, so up to 30 results per input word, set by
//   the single output byte port. With the block idle, a taken word is written
//   to the item queue, then loaded into the output register as the first
//   result. A sample with no copies due gives no result. Stalling pop holds
//   the current result; full rises once four pending items queue behind it.
//   Config: cfg_valid/cfg_ready write cfg_data to register cfg_index; ready is
//   always high. Write only while no results are pending.
//   Reset: registers return to defaults (bit reverse on, U8, ratio 1.0,
//   recording off), phase and peak clear, queues empty.
// ----------------------------------------------------------------------------
module alaw_line_to_pcm_resampler_top
    import alr_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  line_byte,
    input  logic        end_of_block,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  pcm_byte,
    output logic        run_last,
    output logic signed [15:0] record_sample,
    output logic [7:0]  block_peak
);

    alr_cfg_t  cfg_reg;
    alr_item_t fq_wdata;
    alr_item_t fq_rdata;
    logic      fq_push, fq_full, fq_pop, fq_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.bit_reverse   <= 1'b1;
            cfg_reg.out_format    <= FMT_U8;
            cfg_reg.rate_ratio    <= DEF_RATE_RATIO;
            cfg_reg.record_enable <= 1'b0;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BIT_REVERSE:   cfg_reg.bit_reverse   <= cfg_data[0];
                REG_OUT_FORMAT:    cfg_reg.out_format    <= cfg_data[2:0];
                REG_RATE_RATIO:    cfg_reg.rate_ratio    <= cfg_data;
                REG_RECORD_ENABLE: cfg_reg.record_enable <= cfg_data[0];
                default:           cfg_reg.record_enable <= cfg_reg.record_enable;
            endcase
        end
    end

    alr_front #(
        .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .full         (full),
        .line_byte    (line_byte),
        .end_of_block (end_of_block),
        .q_full       (fq_full),
        .q_push       (fq_push),
        .q_data       (fq_wdata)
    );

    alr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_wdata),
        .q_full  (fq_full),
        .rd_en   (fq_pop),
        .rd_data (fq_rdata),
        .q_empty (fq_empty)
    );

    alr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (fq_rdata),
        .q_empty       (fq_empty),
        .q_pop         (fq_pop),
        .empty         (empty),
        .pop           (pop),
        .pcm_byte      (pcm_byte),
        .run_last      (run_last),
        .record_sample (record_sample),
        .block_peak    (block_peak)
    );

endmodule
